### design/rsrg_pkg.sv
// ----------------------------------------------------------------------------
// rsrg_pkg
// Shared types, widths and codes of the radial sine ripple grid.
// ----------------------------------------------------------------------------
package rsrg_pkg;

    // grid and field widths
    localparam int GRID_SIZE_DEF = 8;
    localparam int IDX_W         = 3;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int HEIGHT_W      = 17;

    // offset, square and root widths
    localparam int OFFS_W = IDX_W + CFG_W;       // 19
    localparam int SQ_W   = 2 * OFFS_W;          // 38
    localparam int RAD_W  = SQ_W + 2;            // headroom for root search
    localparam int ROOT_STEPS = (SQ_W + 2) / 2;  // one result bit per step
    localparam int STEP_CNT_W = 5;

    // sine approximation constants
    localparam logic [14:0] SIN_C0 = 15'd21167;
    localparam logic [11:0] SIN_C1 = 12'd2463;
    localparam logic [15:0] SIN_C2 = 16'd51472;
    localparam logic [14:0] SIN_MAX = 15'd32767;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPACING_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPACING_Z   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAVE_NUMBER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE   = 3'd4;

    // register reset values
    localparam logic [CFG_W-1:0] RST_SPACING_X   = 16'd256;
    localparam logic [CFG_W-1:0] RST_SPACING_Z   = 16'd256;
    localparam logic [CFG_W-1:0] RST_WAVE_NUMBER = 16'd256;
    localparam logic [CFG_W-1:0] RST_PHASE_STEP  = 16'd1024;
    localparam logic [CFG_W-1:0] RST_AMPLITUDE   = 16'd256;

    // datapath operations
    typedef logic [3:0] dp_op_t;
    localparam dp_op_t OP_NONE  = 4'd0;
    localparam dp_op_t OP_OFFS  = 4'd1;
    localparam dp_op_t OP_SQR   = 4'd2;
    localparam dp_op_t OP_SUM   = 4'd3;
    localparam dp_op_t OP_ROOT  = 4'd4;
    localparam dp_op_t OP_PHASE = 4'd5;
    localparam dp_op_t OP_SIN1  = 4'd6;
    localparam dp_op_t OP_SIN2  = 4'd7;
    localparam dp_op_t OP_SIN3  = 4'd8;
    localparam dp_op_t OP_SIN4  = 4'd9;
    localparam dp_op_t OP_EMIT  = 4'd10;

    // controller to datapath
    typedef struct packed {
        dp_op_t           op;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] row;
        logic             last;
        logic             step_phase;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

### design/rsrg_ctrl.sv
// ----------------------------------------------------------------------------
// rsrg_ctrl
// Sequencer: walks the grid points and steps the datapath through each one.
// ----------------------------------------------------------------------------
module rsrg_ctrl
    import rsrg_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       advance,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(GRID_SIZE - 1);
    localparam logic [STEP_CNT_W-1:0] STEP_LAST = STEP_CNT_W'(ROOT_STEPS - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_OFFS  = 4'd1;
    localparam logic [3:0] S_SQR   = 4'd2;
    localparam logic [3:0] S_SUM   = 4'd3;
    localparam logic [3:0] S_ROOT  = 4'd4;
    localparam logic [3:0] S_PHASE = 4'd5;
    localparam logic [3:0] S_SIN1  = 4'd6;
    localparam logic [3:0] S_SIN2  = 4'd7;
    localparam logic [3:0] S_SIN3  = 4'd8;
    localparam logic [3:0] S_SIN4  = 4'd9;
    localparam logic [3:0] S_EMIT  = 4'd10;

    logic [3:0]            state_reg, state_next;
    logic [IDX_W-1:0]      col_reg, col_next;
    logic [IDX_W-1:0]      row_reg, row_next;
    logic [STEP_CNT_W-1:0] step_reg, step_next;
    logic                  adv_reg, adv_next;
    logic                  point_last;

    assign point_last = (col_reg == IDX_LAST) && (row_reg == IDX_LAST);
    assign in_stall   = (state_reg != S_IDLE);

    // command to the datapath
    always_comb
    begin
        cmd.col        = col_reg;
        cmd.row        = row_reg;
        cmd.last       = point_last;
        cmd.step_phase = point_last && adv_reg;
        unique case (state_reg)
            S_OFFS:  cmd.op = OP_OFFS;
            S_SQR:   cmd.op = OP_SQR;
            S_SUM:   cmd.op = OP_SUM;
            S_ROOT:  cmd.op = OP_ROOT;
            S_PHASE: cmd.op = OP_PHASE;
            S_SIN1:  cmd.op = OP_SIN1;
            S_SIN2:  cmd.op = OP_SIN2;
            S_SIN3:  cmd.op = OP_SIN3;
            S_SIN4:  cmd.op = OP_SIN4;
            S_EMIT:  cmd.op = status.out_free ? OP_EMIT : OP_NONE;
            default: cmd.op = OP_NONE;
        endcase
    end

    // state and point counters
    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        step_next  = step_reg;
        adv_next   = adv_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    adv_next   = advance;
                    col_next   = '0;
                    row_next   = '0;
                    state_next = S_OFFS;
                end
            end
            S_OFFS:  state_next = S_SQR;
            S_SQR:   state_next = S_SUM;
            S_SUM:
            begin
                step_next  = '0;
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = S_PHASE;
                end
            end
            S_PHASE: state_next = S_SIN1;
            S_SIN1:  state_next = S_SIN2;
            S_SIN2:  state_next = S_SIN3;
            S_SIN3:  state_next = S_SIN4;
            S_SIN4:  state_next = S_EMIT;
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    if (point_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_OFFS;
                        if (row_reg == IDX_LAST)
                        begin
                            row_next = '0;
                            col_next = col_reg + 1'b1;
                        end
                        else
                        begin
                            row_next = row_reg + 1'b1;
                        end
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            step_reg  <= '0;
            adv_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            step_reg  <= step_next;
            adv_reg   <= adv_next;
        end
    end

endmodule

### design/rsrg_dp.sv
// ----------------------------------------------------------------------------
// rsrg_dp
// Datapath: settings, time phase, radius root, phase, sine and output beat.
// ----------------------------------------------------------------------------
module rsrg_dp
    import rsrg_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [CFG_IDX_W-1:0]       wr_index,
    input  logic [CFG_W-1:0]           wr_data,
    input  dp_cmd_t                    cmd,
    output dp_status_t                 status,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [HEIGHT_W-1:0] height,
    output logic [IDX_W-1:0]           col,
    output logic [IDX_W-1:0]           row,
    output logic                       last
);

    // settings and frame state
    logic [CFG_W-1:0] spacing_x_reg, spacing_z_reg, wave_number_reg;
    logic [CFG_W-1:0] phase_step_reg, amplitude_reg, time_phase_reg;

    // working registers
    logic [OFFS_W-1:0] dx_reg, dz_reg;
    logic [SQ_W-1:0]   sqx_reg, sqz_reg;
    logic [RAD_W-1:0]  rem_reg, res_reg, bit_reg;
    logic [15:0]       ph_reg;
    logic [15:0]       t_reg, u_reg, w_reg;
    logic [14:0]       v_reg, s_reg;
    logic              neg_reg;

    // output register
    logic                       out_valid_reg;
    logic signed [HEIGHT_W-1:0] height_reg;
    logic [IDX_W-1:0]           col_reg, row_reg;
    logic                       last_reg;

    // combinational helpers
    logic [RAD_W-1:0] trial;
    logic [31:0]      ph_prod;
    logic [1:0]       quad;
    logic [7:0]       q_pos;
    logic [8:0]       r_pos;
    logic [15:0]      t_val;
    logic [31:0]      tt_prod;
    logic [27:0]      u_c1_prod;
    logic [30:0]      uv_prod;
    logic [31:0]      tw_prod;
    logic [16:0]      s_raw;
    logic [30:0]      amp_prod;
    logic [15:0]      mag_down, mag_up;

    assign status.out_free = !out_valid_reg || !out_stall;

    assign trial     = res_reg + bit_reg;
    assign ph_prod   = res_reg[15:0] * wave_number_reg;
    assign quad      = ph_reg[15:14];
    assign q_pos     = ph_reg[13:6];
    assign r_pos     = quad[0] ? (9'd256 - {1'b0, q_pos}) : {1'b0, q_pos};
    assign t_val     = {r_pos, 7'b0};
    assign tt_prod   = t_val * t_val;
    assign u_c1_prod = u_reg * SIN_C1;
    assign uv_prod   = u_reg * v_reg;
    assign tw_prod   = t_reg * w_reg;
    assign s_raw     = tw_prod[31:15];
    assign amp_prod  = amplitude_reg * s_reg;
    assign mag_down  = amp_prod[30:15];
    assign mag_up    = 16'((amp_prod + 31'd32767) >> 15);

    // configuration writes and time phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_x_reg   <= RST_SPACING_X;
            spacing_z_reg   <= RST_SPACING_Z;
            wave_number_reg <= RST_WAVE_NUMBER;
            phase_step_reg  <= RST_PHASE_STEP;
            amplitude_reg   <= RST_AMPLITUDE;
            time_phase_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                unique case (wr_index)
                    REG_SPACING_X:   spacing_x_reg   <= wr_data;
                    REG_SPACING_Z:   spacing_z_reg   <= wr_data;
                    REG_WAVE_NUMBER: wave_number_reg <= wr_data;
                    REG_PHASE_STEP:  phase_step_reg  <= wr_data;
                    REG_AMPLITUDE:   amplitude_reg   <= wr_data;
                    default:         ;
                endcase
            end
            if (cmd.op == OP_EMIT && cmd.step_phase)
            begin
                time_phase_reg <= time_phase_reg + phase_step_reg;
            end
        end
    end

    // per-point arithmetic, one operation per command
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_OFFS:
            begin
                dx_reg <= cmd.col * spacing_x_reg;
                dz_reg <= cmd.row * spacing_z_reg;
            end
            OP_SQR:
            begin
                sqx_reg <= dx_reg * dx_reg;
                sqz_reg <= dz_reg * dz_reg;
            end
            OP_SUM:
            begin
                rem_reg <= RAD_W'(sqx_reg) + RAD_W'(sqz_reg);
                res_reg <= '0;
                bit_reg <= RAD_W'(1) << (2 * (ROOT_STEPS - 1));
            end
            OP_ROOT:
            begin
                // one result bit per step
                if (rem_reg >= trial)
                begin
                    rem_reg <= rem_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            OP_PHASE:
            begin
                ph_reg <= ph_prod[15:0] - time_phase_reg;
            end
            OP_SIN1:
            begin
                t_reg   <= t_val;
                u_reg   <= tt_prod[30:15];
                neg_reg <= quad[1];
            end
            OP_SIN2:
            begin
                v_reg <= SIN_C0 - 15'(u_c1_prod[27:15]);
            end
            OP_SIN3:
            begin
                w_reg <= SIN_C2 - uv_prod[30:15];
            end
            OP_SIN4:
            begin
                s_reg <= (s_raw > 17'(SIN_MAX)) ? SIN_MAX : s_raw[14:0];
            end
            default: ;
        endcase
    end

    // output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == OP_EMIT)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_EMIT)
        begin
            height_reg <= neg_reg ? -$signed({1'b0, mag_up})
                                  : $signed({1'b0, mag_down});
            col_reg    <= cmd.col;
            row_reg    <= cmd.row;
            last_reg   <= cmd.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign height    = height_reg;
    assign col       = col_reg;
    assign row       = row_reg;
    assign last      = last_reg;

endmodule

### design/radial_sine_ripple_grid.sv
// ----------------------------------------------------------------------------
// radial_sine_ripple_grid
// Emits a radial sine ripple height for every point of a square grid.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall, advance): one beat is one frame tick.
//   Output channel (out_valid/out_stall, height/col/row/last): GRID_SIZE^2
//   beats per frame, column outer, row inner; last marks the final point.
//   Settings are written through wr_en/wr_index/wr_data while idle; indexes
//   beyond the register list are ignored.
// Timing:
//   Each point steps through offsets, squares, sum, 20 steps of the
//   bit-serial square root (one result bit per cycle), phase, four sine
//   steps and the output load. The root loop sets the rate.
//   The next frame tick is taken once the last point is in the output
//   register. in_stall is high while a frame is being worked.
// Reset:
//   rst_n clears the sequencer, the output valid and the time phase, and
//   loads the settings with their defaults.
// Stall:
//   A stalled output beat holds; the sequencer waits at the next point's
//   output load until the register frees.
// ----------------------------------------------------------------------------
module radial_sine_ripple_grid
    import rsrg_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [CFG_IDX_W-1:0]       wr_index,
    input  logic [CFG_W-1:0]           wr_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       advance,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [HEIGHT_W-1:0] height,
    output logic [IDX_W-1:0]           col,
    output logic [IDX_W-1:0]           row,
    output logic                       last
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer
    rsrg_ctrl #(
        .GRID_SIZE (GRID_SIZE)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .advance  (advance),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic and output register
    rsrg_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .height    (height),
        .col       (col),
        .row       (row),
        .last      (last)
    );

endmodule

### verif/rsrg_height_checker.sv
// ----------------------------------------------------------------------------
// rsrg_height_checker
// Watches the settings port and both channels of the ripple grid, predicts
// the height of every grid point of each frame tick and compares each
// output beat against the oldest predicted point.
// ----------------------------------------------------------------------------
module rsrg_height_checker
    import rsrg_pkg::*;
#(
    parameter int GRID = GRID_SIZE_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [CFG_IDX_W-1:0]       wr_index,
    input  logic [CFG_W-1:0]           wr_data,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic                       advance,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic signed [HEIGHT_W-1:0] height,
    input  logic [IDX_W-1:0]           col,
    input  logic [IDX_W-1:0]           row,
    input  logic                       last,
    output int                         mismatches,
    output int                         outstanding,
    output int                         points_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // settings after reset
    localparam logic [CFG_W-1:0] DEF_SPACING   = 16'd256;
    localparam logic [CFG_W-1:0] DEF_WAVE      = 16'd256;
    localparam logic [CFG_W-1:0] DEF_TICK_STEP = 16'd1024;
    localparam logic [CFG_W-1:0] DEF_PEAK      = 16'd256;

    // polynomial sine coefficients, Q15
    localparam longint unsigned SINE_K0   = 21167;
    localparam longint unsigned SINE_K1   = 2463;
    localparam longint unsigned SINE_K2   = 51472;
    localparam longint unsigned SINE_CLIP = 32767;

    typedef struct {
        logic signed [HEIGHT_W-1:0] height;
        logic [IDX_W-1:0]           col;
        logic [IDX_W-1:0]           row;
        logic                       last;
    } grid_point_t;

    grid_point_t pending_points [$];

    logic [CFG_W-1:0] step_x;
    logic [CFG_W-1:0] step_z;
    logic [CFG_W-1:0] wave_k;
    logic [CFG_W-1:0] tick_step;
    logic [CFG_W-1:0] peak;
    logic [15:0]      wave_phase;
    int               fail_count;
    int               checked;

    // one sine table entry, indexed by the top ten phase bits
    function automatic int sine_sample(input logic [9:0] idx);
        longint unsigned ramp;
        longint unsigned t;
        longint unsigned u;
        longint unsigned v;
        longint unsigned w;
        longint unsigned s;
        ramp = idx[8] ? 256 - longint'(idx[7:0]) : longint'(idx[7:0]);
        t = ramp * 128;
        u = (t * t) >> 15;
        v = SINE_K0 - ((u * SINE_K1) >> 15);
        w = SINE_K2 - ((u * v) >> 15);
        s = (t * w) >> 15;
        if (s > SINE_CLIP)
            s = SINE_CLIP;
        return idx[9] ? -int'(s) : int'(s);
    endfunction

    // floor of the square root, one result bit at a time
    function automatic longint unsigned floor_root(input longint unsigned n);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 20; b >= 0; b--)
        begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= n)
                root = trial;
        end
        return root;
    endfunction

    // height of one grid point under the current settings and phase
    function automatic logic signed [HEIGHT_W-1:0] ripple_height(input int unsigned c,
                                                                 input int unsigned r);
        longint unsigned dx;
        longint unsigned dz;
        longint unsigned radius;
        logic [15:0]     phase;
        longint          prod;
        dx = longint'(c) * longint'(step_x);
        dz = longint'(r) * longint'(step_z);
        radius = floor_root(dx * dx + dz * dz);
        phase = 16'(radius * longint'(wave_k)) - wave_phase;
        prod = longint'(peak) * longint'(sine_sample(phase[15:6]));
        return HEIGHT_W'(prod >>> 15);
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        grid_point_t want;
        grid_point_t pt;
        if (!rst_n)
        begin
            pending_points.delete();
            step_x         = DEF_SPACING;
            step_z         = DEF_SPACING;
            wave_k         = DEF_WAVE;
            tick_step      = DEF_TICK_STEP;
            peak           = DEF_PEAK;
            wave_phase     = '0;
            fail_count     = 0;
            checked        = 0;
            mismatches     <= 0;
            outstanding    <= 0;
            points_checked <= 0;
        end
        else
        begin
            // output beat against the oldest predicted point
            if (out_valid && !out_stall)
            begin
                if (pending_points.size() == 0)
                    report_mismatch($sformatf("beat col %0d row %0d with no point pending",
                                              col, row));
                else
                begin
                    want = pending_points.pop_front();
                    checked++;
                    if (height !== want.height)
                        report_mismatch($sformatf("point (%0d,%0d) height %0d, want %0d",
                                                  want.col, want.row, height, want.height));
                    if (col !== want.col)
                        report_mismatch($sformatf("col %0d, want %0d", col, want.col));
                    if (row !== want.row)
                        report_mismatch($sformatf("row %0d, want %0d", row, want.row));
                    if (last !== want.last)
                        report_mismatch($sformatf("point (%0d,%0d) last %b, want %b",
                                                  want.col, want.row, last, want.last));
                end
            end

            // settings writes, unmapped indexes fall through
            if (wr_en)
            begin
                case (wr_index)
                    REG_SPACING_X:   step_x = wr_data;
                    REG_SPACING_Z:   step_z = wr_data;
                    REG_WAVE_NUMBER: wave_k = wr_data;
                    REG_PHASE_STEP:  tick_step = wr_data;
                    REG_AMPLITUDE:   peak = wr_data;
                    default:         ;
                endcase
            end

            // frame tick: predict every point, then move the phase when advance is set
            if (in_valid && !in_stall)
            begin
                for (int unsigned c = 0; c < GRID; c++)
                begin
                    for (int unsigned r = 0; r < GRID; r++)
                    begin
                        pt.height = ripple_height(c, r);
                        pt.col    = IDX_W'(c);
                        pt.row    = IDX_W'(r);
                        pt.last   = (c == GRID - 1) && (r == GRID - 1);
                        pending_points.push_back(pt);
                    end
                end
                if (advance)
                    wave_phase = wave_phase + tick_step;
            end

            mismatches     <= fail_count;
            outstanding    <= pending_points.size();
            points_checked <= checked;
        end
    end

endmodule

### verif/radial_sine_ripple_grid_tb.sv
// ----------------------------------------------------------------------------
// radial_sine_ripple_grid_tb
// Drives frame ticks and settings into the ripple grid under random input
// gaps and output stalls; a checker beside the block predicts every point
// and compares. Directed corner settings come first, then random phases.
// ----------------------------------------------------------------------------
module radial_sine_ripple_grid_tb
    import rsrg_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_LAST  = 3'd7;
    localparam logic [CFG_W-1:0]     CFG_MAX            = '1;
    localparam int CYCLE_LIMIT     = 5_000_000;
    localparam int RAND_PHASES     = 12;
    localparam int CALM_PHASES     = 2;
    localparam int TICKS_PER_PHASE = 35;
    localparam int TAIL_CYCLES     = 64;

    logic                       clk;
    logic                       rst_n     = 1'b0;
    logic                       wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]       wr_index  = REG_SPACING_X;
    logic [CFG_W-1:0]           wr_data   = '0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    logic                       advance   = 1'b0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [HEIGHT_W-1:0] height;
    logic [IDX_W-1:0]           col;
    logic [IDX_W-1:0]           row;
    logic                       last;

    int mismatches;
    int outstanding;
    int points_checked;
    int ticks_sent     = 0;
    int settings_loads = 0;
    int cycle_count    = 0;
    bit calm           = 1'b0;

    radial_sine_ripple_grid u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .advance   (advance),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .height    (height),
        .col       (col),
        .row       (row),
        .last      (last)
    );

    rsrg_height_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr_en          (wr_en),
        .wr_index       (wr_index),
        .wr_data        (wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .advance        (advance),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .height         (height),
        .col            (col),
        .row            (row),
        .last           (last),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .points_checked (points_checked)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d points still pending",
                     cycle_count, outstanding);
            $display("FAIL radial_sine_ripple_grid");
            $finish;
        end
    end

    // output stall bursts, none once the run goes calm
    initial
    begin
        forever
        begin
            if (calm || $urandom_range(0, 2) != 0)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
        end
    end

    // settings value biased toward the extremes and small spacings
    function automatic logic [CFG_W-1:0] pick_setting();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CFG_MAX;
            2:       return CFG_W'($urandom_range(1, 64));
            3:       return CFG_W'($urandom_range(64, 1023));
            default: return CFG_W'($urandom);
        endcase
    endfunction

    // all five registers, then a write to an unmapped index
    task automatic apply_settings(input logic [CFG_W-1:0] sx, sz, wn, ps, amp);
        logic [CFG_IDX_W-1:0] idx_list [6];
        logic [CFG_W-1:0]     val_list [6];
        idx_list = '{REG_SPACING_X, REG_SPACING_Z, REG_WAVE_NUMBER, REG_PHASE_STEP,
                     REG_AMPLITUDE,
                     CFG_IDX_W'($urandom_range(IDX_UNMAPPED_LAST, IDX_UNMAPPED_FIRST))};
        val_list = '{sx, sz, wn, ps, amp, CFG_W'($urandom)};
        foreach (idx_list[i])
        begin
            wr_en    <= 1'b1;
            wr_index <= idx_list[i];
            wr_data  <= val_list[i];
            @(posedge clk);
        end
        wr_en <= 1'b0;
        settings_loads++;
    endtask

    // one frame tick beat, with an optional gap after it
    task automatic push_tick(input logic adv);
        in_valid <= 1'b1;
        advance  <= adv;
        do
            @(posedge clk);
        while (in_stall);
        ticks_sent++;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            advance  <= 1'($urandom);
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    // hold off the sender until every predicted point has come out
    task automatic drain_frames();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // stimulus
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, both advance values
        push_tick(1'b1);
        push_tick(1'b0);
        push_tick(1'b1);
        push_tick(1'b1);
        drain_frames();

        // everything at full scale: widest products, largest heights
        apply_settings(CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX);
        push_tick(1'b1);
        push_tick(1'b1);
        push_tick(1'b0);
        drain_frames();

        // everything zero
        apply_settings('0, '0, '0, '0, '0);
        push_tick(1'b1);
        push_tick(1'b0);
        drain_frames();

        // wide column spacing, flat rows, half-turn steps
        apply_settings(CFG_MAX, '0, 16'd1, 16'h8000, CFG_MAX);
        push_tick(1'b1);
        push_tick(1'b1);
        drain_frames();

        // wide row spacing, tiny amplitude to exercise floor rounding
        apply_settings(16'd1, CFG_MAX, CFG_MAX, 16'd1, 16'd1);
        push_tick(1'b1);
        push_tick(1'b0);
        drain_frames();

        // fractional spacing, mid-range values
        apply_settings(16'h0080, 16'h0100, 16'h4000, 16'h7FFF, 16'h8000);
        push_tick(1'b1);
        push_tick(1'b1);
        drain_frames();

        // random phases, the last ones without idling
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            calm = (ph >= RAND_PHASES - CALM_PHASES);
            apply_settings(pick_setting(), pick_setting(), pick_setting(),
                           pick_setting(), pick_setting());
            for (int k = 0; k < TICKS_PER_PHASE; k++)
            begin
                push_tick(1'($urandom_range(0, 1)));
                if (!calm && $urandom_range(0, 39) == 0)
                    drain_frames();
            end
            drain_frames();
        end

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d frame ticks over %0d settings loads, %0d grid points compared",
                 ticks_sent, settings_loads, points_checked);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS radial_sine_ripple_grid");
        else
        begin
            $display("%0d mismatches, %0d points never seen", mismatches, outstanding);
            $display("FAIL radial_sine_ripple_grid");
        end
        $finish;
    end

endmodule

### sim.f
design/rsrg_pkg.sv
design/rsrg_ctrl.sv
design/rsrg_dp.sv
design/radial_sine_ripple_grid.sv
verif/rsrg_height_checker.sv
verif/radial_sine_ripple_grid_tb.sv
